// File: hw/rtl/rgc_pkg.sv
// rgc_pkg: shared constants and types of the recursive Gaussian column filter.
// Used by every module of the block; depends on nothing.
package rgc_pkg;

    localparam int MAX_HEIGHT = 64;
    localparam int ROW_W      = 6;
    localparam int CNT_W      = 7;
    localparam int LANES      = 3;
    localparam int PIX_W      = 8;
    localparam int COL_W      = 10;
    localparam int COEF_W     = 18;
    localparam int COEF_FRAC  = 14;
    localparam int STATE_FRAC = 8;
    localparam int STATE_W    = 13 + STATE_FRAC;
    localparam int OPND_W     = STATE_W + 1;
    localparam int PROD_W     = COEF_W + OPND_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int STORE_W    = 2 * LANES * PIX_W;
    localparam int ADDR_W     = 5;
    localparam int STEP_W     = 3;
    localparam int NUM_TERMS  = 4;

    typedef struct packed {
        logic signed [COEF_W-1:0] a0;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] a3;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
    } coef_t;

    typedef struct packed {
        logic       bwd;
        logic       first;
        logic [1:0] term;
        logic       load;
        logic       accum;
        logic       fwd_commit;
        logic       col_reset;
        logic       bwd_commit;
    } lane_ctl_t;

endpackage

// File: hw/rtl/rgc_regs.sv
// rgc_regs: APB register file holding mode, lane select and filter coefficients.
// Depends on rgc_pkg.
module rgc_regs import rgc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic              mode,
    output logic              single,
    output coef_t             coef
);

    typedef enum logic [2:0] {
        REG_MODE, REG_SINGLE, REG_A0, REG_A1, REG_A2, REG_A3, REG_B1, REG_B2
    } reg_idx_t;

    logic     mode_reg;
    logic     single_reg;
    coef_t    coef_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign mode   = mode_reg;
    assign single = single_reg;
    assign coef   = coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b1;
            single_reg <= 1'b0;
            coef_reg   <= '0;
        end
        else if (wr)
        begin
            case (idx)
                REG_MODE:   mode_reg    <= pwdata[0];
                REG_SINGLE: single_reg  <= pwdata[0];
                REG_A0:     coef_reg.a0 <= pwdata[COEF_W-1:0];
                REG_A1:     coef_reg.a1 <= pwdata[COEF_W-1:0];
                REG_A2:     coef_reg.a2 <= pwdata[COEF_W-1:0];
                REG_A3:     coef_reg.a3 <= pwdata[COEF_W-1:0];
                REG_B1:     coef_reg.b1 <= pwdata[COEF_W-1:0];
                REG_B2:     coef_reg.b2 <= pwdata[COEF_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MODE:   prdata = {31'd0, mode_reg};
            REG_SINGLE: prdata = {31'd0, single_reg};
            REG_A0:     prdata = 32'(coef_reg.a0);
            REG_A1:     prdata = 32'(coef_reg.a1);
            REG_A2:     prdata = 32'(coef_reg.a2);
            REG_A3:     prdata = 32'(coef_reg.a3);
            REG_B1:     prdata = 32'(coef_reg.b1);
            REG_B2:     prdata = 32'(coef_reg.b2);
            default:    prdata = 32'd0;
        endcase
    end

endmodule

// File: hw/rtl/rgc_store.sv
// rgc_store: column memory, one row per entry: forward results over raw samples.
// Synchronous write, registered read. Depends on rgc_pkg.
module rgc_store import rgc_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ROW_W-1:0]   wr_addr,
    input  logic [STORE_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ROW_W-1:0]   rd_addr,
    output logic [STORE_W-1:0] rd_data
);

    logic [STORE_W-1:0] mem [MAX_HEIGHT];
    logic [STORE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // hold read word until the next read
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/rgc_lane.sv
// rgc_lane: one color lane: shared multiply-accumulate over four terms per row,
// causal and anticausal recursion state, rounding and 8-bit conversion. Uses rgc_pkg.
module rgc_lane import rgc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lane_ctl_t        ctl,
    input  coef_t            coef,
    input  logic             mode,
    input  logic [PIX_W-1:0] sample,
    input  logic [PIX_W-1:0] col_sample,
    input  logic [PIX_W-1:0] fwd_pixel,
    output logic [PIX_W-1:0] fwd8,
    output logic [PIX_W-1:0] pixel
);

    localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'((1 << (STATE_W-1)) - 1);
    localparam logic signed [ACC_W:0] SAT_LO = -SAT_HI - (ACC_W+1)'(1);

    logic [PIX_W-1:0]          prev_sample_reg;
    logic signed [STATE_W-1:0] prev_out_reg;
    logic signed [STATE_W-1:0] older_out_reg;
    logic [PIX_W-1:0]          xn_reg;
    logic [PIX_W-1:0]          xa_reg;
    logic signed [STATE_W-1:0] yn_reg;
    logic signed [STATE_W-1:0] ya_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    logic signed [OPND_W-1:0]  x_fwd;
    logic signed [OPND_W-1:0]  x_col;
    logic signed [OPND_W-1:0]  xsel;
    logic signed [OPND_W-1:0]  ypsel;
    logic signed [OPND_W-1:0]  opnd;
    logic signed [COEF_W-1:0]  coef_sel;
    logic signed [PROD_W-1:0]  prod_full;
    logic signed [ACC_W:0]     acc_x;
    logic signed [ACC_W:0]     rec_q;
    logic signed [ACC_W:0]     sim_q;
    logic signed [ACC_W:0]     ysum;
    logic signed [STATE_W-1:0] y;
    logic [PIX_W-1:0]          y8;
    logic [PIX_W:0]            rec_sum;
    logic signed [STATE_W+1:0] sim_sum;
    logic signed [STATE_W+1:0] sim_half;

    function automatic logic [PIX_W-1:0] to8(input logic signed [STATE_W-1:0] q);
        logic signed [STATE_W-STATE_FRAC-1:0] t;
        t = q[STATE_W-1:STATE_FRAC];
        if (t < 0)
            return '0;
        else if (t > (STATE_W-STATE_FRAC)'(255))
            return 8'd255;
        else
            return t[PIX_W-1:0];
    endfunction

    assign x_fwd = $signed({{(OPND_W-PIX_W-STATE_FRAC){1'b0}}, sample, {STATE_FRAC{1'b0}}});
    assign x_col = $signed({{(OPND_W-PIX_W-STATE_FRAC){1'b0}}, col_sample,
                            {STATE_FRAC{1'b0}}});
    assign xsel  = ctl.bwd ? x_col : x_fwd;

    always_comb
    begin
        if (ctl.bwd)
            ypsel = OPND_W'(yn_reg);
        else if (ctl.first)
            ypsel = x_fwd;
        else
            ypsel = OPND_W'(prev_out_reg);
    end

    // pick the coefficient and operand of the current term; negate feedback operands
    always_comb
    begin
        coef_sel = '0;
        opnd     = '0;
        if (!mode)
        begin
            if (ctl.term == 2'd0)
            begin
                coef_sel = coef.b1;
                opnd     = xsel - ypsel;
            end
        end
        else
        begin
            case (ctl.term)
                2'd0:
                begin
                    coef_sel = ctl.bwd ? coef.a2 : coef.a0;
                    opnd     = ctl.bwd ? $signed({{(OPND_W-PIX_W-STATE_FRAC){1'b0}}, xn_reg,
                                                  {STATE_FRAC{1'b0}}}) : x_fwd;
                end
                2'd1:
                begin
                    coef_sel = ctl.bwd ? coef.a3 : coef.a1;
                    opnd     = $signed({{(OPND_W-PIX_W-STATE_FRAC){1'b0}},
                                        ctl.bwd ? xa_reg : prev_sample_reg,
                                        {STATE_FRAC{1'b0}}});
                end
                2'd2:
                begin
                    coef_sel = coef.b1;
                    opnd     = -OPND_W'(ctl.bwd ? yn_reg : prev_out_reg);
                end
                2'd3:
                begin
                    coef_sel = coef.b2;
                    opnd     = -OPND_W'(ctl.bwd ? ya_reg : older_out_reg);
                end
                default:
                begin
                    coef_sel = '0;
                    opnd     = '0;
                end
            endcase
        end
    end

    assign prod_full = coef_sel * opnd;

    // round half up, then saturate to the state width
    assign acc_x = (ACC_W+1)'(acc_reg);
    assign rec_q = (acc_x + (ACC_W+1)'(1 << (COEF_FRAC-1))) >>> COEF_FRAC;
    assign sim_q = (acc_x + (ACC_W+1)'(1 << COEF_FRAC)) >>> (COEF_FRAC+1);
    assign ysum  = mode ? rec_q : sim_q + (ACC_W+1)'(xsel);

    always_comb
    begin
        if (ysum > SAT_HI)
            y = STATE_W'(SAT_HI);
        else if (ysum < SAT_LO)
            y = STATE_W'(SAT_LO);
        else
            y = ysum[STATE_W-1:0];
    end

    assign y8       = to8(y);
    assign fwd8     = y8;
    assign rec_sum  = {1'b0, fwd_pixel} + {1'b0, y8};
    assign sim_sum  = $signed({{(STATE_W+2-PIX_W-STATE_FRAC){1'b0}}, fwd_pixel,
                               {STATE_FRAC{1'b0}}}) + (STATE_W+2)'(y);
    assign sim_half = sim_sum >>> (STATE_FRAC+1);

    always_comb
    begin
        if (mode)
            pixel = rec_sum[PIX_W] ? 8'd255 : rec_sum[PIX_W-1:0];
        else if (sim_half < 0)
            pixel = '0;
        else if (sim_half > (STATE_W+2)'(255))
            pixel = 8'd255;
        else
            pixel = sim_half[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full;
        if (ctl.load)
            acc_reg <= ACC_W'(prod_reg);
        else if (ctl.accum)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            prev_out_reg    <= '0;
            older_out_reg   <= '0;
            xn_reg          <= '0;
            xa_reg          <= '0;
            yn_reg          <= '0;
            ya_reg          <= '0;
        end
        else
        begin
            if (ctl.fwd_commit)
            begin
                if (ctl.col_reset)
                begin
                    prev_sample_reg <= '0;
                    prev_out_reg    <= '0;
                    older_out_reg   <= '0;
                    // seed the backward pass: closing sample in simple mode, zero in recursive mode
                    xn_reg <= '0;
                    xa_reg <= '0;
                    ya_reg <= '0;
                    yn_reg <= mode ? '0 : STATE_W'(x_fwd);
                end
                else
                begin
                    prev_sample_reg <= sample;
                    prev_out_reg    <= y;
                    if (mode)
                        older_out_reg <= prev_out_reg;
                end
            end
            if (ctl.bwd_commit)
            begin
                xa_reg <= xn_reg;
                xn_reg <= col_sample;
                ya_reg <= yn_reg;
                yn_reg <= y;
            end
        end
    end

endmodule

// File: hw/rtl/recursive_gaussian_column.sv
// Recursive Gaussian column filter, top level: sequencer, register file,
// column memory and three lanes. Depends on rgc_pkg, rgc_regs, rgc_store, rgc_lane.
// Each sample keeps busy high while 4 multiply terms go through one multiplier per lane,
// followed by drain and write-back; a new sample is taken only while busy is low.
// A closing sample then runs the backward pass (memory read, 4 terms, result) for each
// row, one result per row from the bottom row up; results cannot be stalled.
// Reset clears the sequencer, registers and recursion state; memory needs no clearing.
module recursive_gaussian_column import rgc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [COL_W-1:0]  column_index,
    input  logic [PIX_W-1:0]  sample_red,
    input  logic [PIX_W-1:0]  sample_green,
    input  logic [PIX_W-1:0]  sample_blue,
    input  logic              last_in_column,
    output logic              result_strobe,
    output logic [COL_W-1:0]  out_column,
    output logic [ROW_W-1:0]  out_row,
    output logic [PIX_W-1:0]  pixel_red,
    output logic [PIX_W-1:0]  pixel_green,
    output logic [PIX_W-1:0]  pixel_blue,
    output logic              last_of_run
);

    typedef enum logic [2:0] {S_IDLE, S_FMAC, S_FFIN, S_BRD, S_BMAC, S_BFIN} state_t;

    state_t             state_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [CNT_W-1:0]   fill_count_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic               last_reg;
    logic [PIX_W-1:0]   samp_reg [LANES];
    logic               strobe_reg;
    logic [COL_W-1:0]   out_column_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [PIX_W-1:0]   pix_reg [LANES];
    logic               last_of_run_reg;

    logic               mode;
    logic               single;
    coef_t              coef;
    lane_ctl_t          ctl;
    logic [ROW_W-1:0]   fill_row;
    logic               close;
    logic               in_mac;
    logic [STORE_W-1:0] wr_data;
    logic [STORE_W-1:0] rd_data;
    logic [PIX_W-1:0]   fwd8_w [LANES];
    logic [PIX_W-1:0]   pix_w [LANES];

    rgc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (mode),
        .single  (single),
        .coef    (coef)
    );

    assign fill_row = fill_count_reg[ROW_W-1:0];
    assign close    = last_reg || (fill_row == ROW_W'(MAX_HEIGHT - 1));
    assign in_mac   = (state_reg == S_FMAC) || (state_reg == S_BMAC);

    always_comb
    begin
        ctl.bwd        = (state_reg == S_BMAC) || (state_reg == S_BFIN);
        ctl.first      = (fill_row == '0);
        ctl.term       = step_reg[1:0];
        ctl.load       = in_mac && (step_reg == STEP_W'(1));
        ctl.accum      = in_mac && (step_reg > STEP_W'(1));
        ctl.fwd_commit = (state_reg == S_FFIN);
        ctl.col_reset  = (state_reg == S_FFIN) && close;
        ctl.bwd_commit = (state_reg == S_BFIN);
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        rgc_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .coef       (coef),
            .mode       (mode),
            .sample     (samp_reg[l]),
            .col_sample (rd_data[l*PIX_W +: PIX_W]),
            .fwd_pixel  (rd_data[(LANES+l)*PIX_W +: PIX_W]),
            .fwd8       (fwd8_w[l]),
            .pixel      (pix_w[l])
        );
        assign wr_data[l*PIX_W +: PIX_W]         = samp_reg[l];
        assign wr_data[(LANES+l)*PIX_W +: PIX_W] = fwd8_w[l];
    end

    rgc_store u_store (
        .clk     (clk),
        .wr_en   (state_reg == S_FFIN),
        .wr_addr (fill_row),
        .wr_data (wr_data),
        .rd_en   (state_reg == S_BRD),
        .rd_addr (row_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_reg        <= '0;
            fill_count_reg  <= '0;
            row_reg         <= '0;
            last_reg        <= 1'b0;
            strobe_reg      <= 1'b0;
            last_of_run_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        col_reg     <= column_index;
                        last_reg    <= last_in_column;
                        samp_reg[0] <= sample_red;
                        samp_reg[1] <= single ? '0 : sample_green;
                        samp_reg[2] <= single ? '0 : sample_blue;
                        step_reg    <= '0;
                        state_reg   <= S_FMAC;
                    end
                end
                S_FMAC:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(NUM_TERMS))
                        state_reg <= S_FFIN;
                end
                S_FFIN:
                begin
                    if (close)
                    begin
                        fill_count_reg <= '0;
                        row_reg        <= fill_row;
                        state_reg      <= S_BRD;
                    end
                    else
                    begin
                        fill_count_reg <= fill_count_reg + CNT_W'(1);
                        state_reg      <= S_IDLE;
                    end
                end
                S_BRD:
                begin
                    step_reg  <= '0;
                    state_reg <= S_BMAC;
                end
                S_BMAC:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(NUM_TERMS))
                        state_reg <= S_BFIN;
                end
                S_BFIN:
                begin
                    strobe_reg      <= 1'b1;
                    out_column_reg  <= col_reg;
                    out_row_reg     <= row_reg;
                    pix_reg[0]      <= pix_w[0];
                    pix_reg[1]      <= single ? '0 : pix_w[1];
                    pix_reg[2]      <= single ? '0 : pix_w[2];
                    last_of_run_reg <= (row_reg == '0);
                    if (row_reg == '0)
                        state_reg <= S_IDLE;
                    else
                    begin
                        row_reg   <= row_reg - ROW_W'(1);
                        state_reg <= S_BRD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign out_column    = out_column_reg;
    assign out_row       = out_row_reg;
    assign pixel_red     = pix_reg[0];
    assign pixel_green   = pix_reg[1];
    assign pixel_blue    = pix_reg[2];
    assign last_of_run   = last_of_run_reg;

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_run_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last_of_run |-> state_reg == S_IDLE)
        else $error("sequencer still running after row zero");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last_of_run |-> state_reg == S_BRD)
        else $error("backward pass stopped before row zero");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg < CNT_W'(MAX_HEIGHT))
        else $error("fill count beyond column height");

    a_fill_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> fill_count_reg == '0)
        else $error("fill count not cleared during backward pass");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench of recursive_gaussian_column, with its own column predictor.
// Depends on rgc_pkg and the recursive_gaussian_column RTL.
module tb;
    import rgc_pkg::*;

    typedef enum int {
        REG_FILTER_MODE, REG_SINGLE_CHANNEL, REG_FF_ZERO, REG_FF_ONE,
        REG_FB_FWD_TWO, REG_FB_FWD_THREE, REG_FB_ONE, REG_FB_TWO
    } reg_index_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam longint STATE_HI = (longint'(1) <<< (STATE_W - 1)) - 1;
    localparam longint STATE_LO = -STATE_HI - 1;

    typedef struct {
        bit [COL_W-1:0] col;
        bit [PIX_W-1:0] red, green, blue;
        bit             last;
    } sample_word_t;

    typedef struct {
        bit [COL_W-1:0] col;
        bit [ROW_W-1:0] row;
        bit [PIX_W-1:0] red, green, blue;
        bit             last;
    } pixel_word_t;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              start = 0;
    logic              busy;
    logic [COL_W-1:0]  column_index = '0;
    logic [PIX_W-1:0]  sample_red = '0, sample_green = '0, sample_blue = '0;
    logic              last_in_column = 0;
    logic              result_strobe;
    logic [COL_W-1:0]  out_column;
    logic [ROW_W-1:0]  out_row;
    logic [PIX_W-1:0]  pixel_red, pixel_green, pixel_blue;
    logic              last_of_run;

    recursive_gaussian_column uut (.*);

    always #5 clk = ~clk;

    // predictor copy of registers and column state
    bit     mode_recursive = 1;
    bit     mono = 0;
    longint coef [6];
    bit [7:0] column_mem [MAX_HEIGHT][LANES];
    bit [7:0] causal_mem [MAX_HEIGHT][LANES];
    int       rows_held = 0;
    bit [7:0] last_px [LANES];
    longint   y_prev [LANES];
    longint   y_older [LANES];

    pixel_word_t pending_pixels[$];
    int errors = 0;
    int cycles = 0;
    int words_sent = 0;
    int runs_done = 0;
    bit quiet = 0;

    function automatic longint rnd_shr(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clip_state(longint v);
        return v > STATE_HI ? STATE_HI : (v < STATE_LO ? STATE_LO : v);
    endfunction

    function automatic bit [7:0] clip8(longint v);
        return v < 0 ? 8'd0 : (v > 255 ? 8'd255 : v[7:0]);
    endfunction

    function automatic bit [7:0] narrow(longint q);
        return clip8(q >>> STATE_FRAC);
    endfunction

    function automatic longint smooth(longint x, longint yp);
        return clip_state(x + rnd_shr((yp - x) * (-coef[4]), COEF_FRAC + 1));
    endfunction

    function automatic void predict(sample_word_t w);
        int n, cnt, r, l;
        longint x, y, acc, xc, yc;
        longint xn [LANES], xa [LANES], yn [LANES], ya [LANES];
        bit [7:0] s, v;
        bit [7:0] lane [LANES];
        pixel_word_t p;
        lane[0] = w.red; lane[1] = w.green; lane[2] = w.blue;
        n = rows_held >= MAX_HEIGHT ? 0 : rows_held;
        for (l = 0; l < LANES; l++)
        begin
            s = (mono && l > 0) ? 8'd0 : lane[l];
            column_mem[n][l] = s;
            x = longint'(s) <<< STATE_FRAC;
            if (mode_recursive)
            begin
                acc = coef[0] * x + coef[1] * (longint'(last_px[l]) <<< STATE_FRAC)
                    - coef[4] * y_prev[l] - coef[5] * y_older[l];
                y = clip_state(rnd_shr(acc, COEF_FRAC));
                y_older[l] = y_prev[l];
            end
            else
                y = smooth(x, n == 0 ? x : y_prev[l]);
            y_prev[l] = y;
            last_px[l] = s;
            causal_mem[n][l] = narrow(y);
        end
        rows_held = n + 1;
        if (!(w.last || rows_held >= MAX_HEIGHT))
            return;
        cnt = rows_held;
        for (l = 0; l < LANES; l++)
        begin
            xn[l] = 0; xa[l] = 0; ya[l] = 0;
            yn[l] = mode_recursive ? 0 : longint'(column_mem[cnt-1][l]) <<< STATE_FRAC;
        end
        // drain bottom to top
        for (r = cnt - 1; r >= 0; r--)
        begin
            for (l = 0; l < LANES; l++)
            begin
                xc = longint'(column_mem[r][l]) <<< STATE_FRAC;
                if (mode_recursive)
                begin
                    acc = coef[2] * xn[l] + coef[3] * xa[l] - coef[4] * yn[l] - coef[5] * ya[l];
                    yc = clip_state(rnd_shr(acc, COEF_FRAC));
                    xa[l] = xn[l]; xn[l] = xc; ya[l] = yn[l]; yn[l] = yc;
                    v = clip8(longint'(causal_mem[r][l]) + longint'(narrow(yc)));
                end
                else
                begin
                    yc = smooth(xc, yn[l]);
                    yn[l] = yc;
                    v = clip8(((longint'(causal_mem[r][l]) <<< STATE_FRAC) + yc)
                              >>> (STATE_FRAC + 1));
                end
                if (mono && l > 0)
                    v = 8'd0;
                lane[l] = v;
            end
            p.col = w.col; p.row = ROW_W'(r); p.last = (r == 0);
            p.red = lane[0]; p.green = lane[1]; p.blue = lane[2];
            pending_pixels.push_back(p);
        end
        rows_held = 0;
        for (l = 0; l < LANES; l++)
        begin
            last_px[l] = 8'd0; y_prev[l] = 0; y_older[l] = 0;
        end
        runs_done++;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[recursive_gaussian_column] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        pixel_word_t e;
        if (rst_n && result_strobe)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel word with nothing pending: row %0d", out_row);
                errors++;
            end
            else
            begin
                e = pending_pixels.pop_front();
                check_field("out_column", e.col, out_column);
                check_field("out_row", e.row, out_row);
                check_field("pixel_red", e.red, pixel_red);
                check_field("pixel_green", e.green, pixel_green);
                check_field("pixel_blue", e.blue, pixel_blue);
                check_field("last_of_run", e.last, last_of_run);
            end
        end
    end

    // hold start high until the block takes the word
    task automatic send_sample(bit [COL_W-1:0] col, bit [7:0] r, bit [7:0] g,
                               bit [7:0] b, bit last);
        sample_word_t w;
        if (!quiet && $urandom_range(99) < 14)
        begin
            start <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1;
        column_index <= col; sample_red <= r; sample_green <= g; sample_blue <= b;
        last_in_column <= last;
        w.col = col; w.red = r; w.green = g; w.blue = b; w.last = last;
        do @(posedge clk); while (busy);
        predict(w);
        words_sent++;
    endtask

    task automatic drain();
        start <= 0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, int value);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= ADDR_W'(4 * idx); pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge clk);
        case (idx)
            REG_FILTER_MODE:    mode_recursive = value[0];
            REG_SINGLE_CHANNEL: mono = value[0];
            default:            coef[idx - REG_FF_ZERO] = longint'($signed(value[17:0]));
        endcase
    endtask

    task automatic set_coefs(int a0, int a1, int a2, int a3, int b1, int b2);
        write_reg(REG_FF_ZERO, a0);
        write_reg(REG_FF_ONE, a1);
        write_reg(REG_FB_FWD_TWO, a2);
        write_reg(REG_FB_FWD_THREE, a3);
        write_reg(REG_FB_ONE, b1);
        write_reg(REG_FB_TWO, b2);
    endtask

    task automatic random_columns(int count);
        int len, i, target;
        bit [COL_W-1:0] col;
        target = words_sent + count;
        while (words_sent < target)
        begin
            // mostly short closed columns, now and then a full one
            len = ($urandom_range(11) == 0) ? MAX_HEIGHT : $urandom_range(1, 10);
            // close the last column within the word budget
            if (len > target - words_sent)
                len = target - words_sent;
            col = COL_W'($urandom);
            for (i = 0; i < len; i++)
                send_sample(($urandom_range(9) == 0) ? COL_W'($urandom) : col,
                            8'($urandom), 8'($urandom), 8'($urandom),
                            (i == len - 1) ? (len < MAX_HEIGHT || $urandom_range(1)) : 1'b0);
        end
    endtask

    task automatic test_reset_defaults();
        send_sample(10'd5, 8'd200, 8'd100, 8'd50, 1'b0);
        send_sample(10'd5, 8'd7, 8'd8, 8'd9, 1'b1);
        drain();
    endtask

    task automatic test_edges();
        set_coefs(4000, 2000, 2000, -500, -13000, 2700);
        send_sample(10'd1023, 8'd255, 8'd255, 8'd255, 1'b1);
        send_sample(10'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_sample(10'd0, 8'd255, 8'd0, 8'd255, 1'b1);
        send_sample(10'd512, 8'd1, 8'd128, 8'd254, 1'b0);
        send_sample(10'd512, 8'd128, 8'd1, 8'd127, 1'b0);
        send_sample(10'd511, 8'd255, 8'd255, 8'd0, 1'b1);
        drain();
        // saturate state and the 8-bit sum
        set_coefs(131071, 131071, 131071, 131071, -131072, -131072);
        send_sample(10'd3, 8'd255, 8'd255, 8'd255, 1'b0);
        send_sample(10'd3, 8'd255, 8'd0, 8'd255, 1'b0);
        send_sample(10'd3, 8'd255, 8'd255, 8'd255, 1'b1);
        drain();
        set_coefs(-131072, -131072, -131072, -131072, 131071, 131071);
        send_sample(10'd4, 8'd255, 8'd10, 8'd255, 1'b0);
        send_sample(10'd4, 8'd255, 8'd200, 8'd0, 1'b1);
        drain();
        write_reg(REG_SINGLE_CHANNEL, 1);
        set_coefs(4000, 2000, 2000, -500, -13000, 2700);
        send_sample(10'd6, 8'd90, 8'd255, 8'd255, 1'b0);
        send_sample(10'd6, 8'd250, 8'd255, 8'd255, 1'b1);
        drain();
        write_reg(REG_SINGLE_CHANNEL, 0);
        write_reg(REG_FILTER_MODE, 0);
        send_sample(10'd7, 8'd255, 8'd0, 8'd99, 1'b1);
        send_sample(10'd8, 8'd0, 8'd255, 8'd30, 1'b0);
        send_sample(10'd8, 8'd255, 8'd0, 8'd60, 1'b1);
        drain();
    endtask

    // column closed by height alone, with last_in_column never set
    task automatic test_full_column();
        int i;
        write_reg(REG_FILTER_MODE, 1);
        set_coefs(4000, 2000, 2000, -500, -13000, 2700);
        for (i = 0; i < MAX_HEIGHT; i++)
            send_sample(10'd77, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        drain();
    endtask

    task automatic test_recursive_random();
        write_reg(REG_FILTER_MODE, 1);
        set_coefs(4000, 2000, 2000, -500, -13000, 2700);
        random_columns(12);
        drain();
        set_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_columns(8);
        drain();
    endtask

    task automatic test_simple_random();
        write_reg(REG_FILTER_MODE, 0);
        write_reg(REG_FB_ONE, -16384);
        random_columns(6);
        drain();
        write_reg(REG_FB_ONE, -131072);
        random_columns(4);
        drain();
        write_reg(REG_FB_ONE, 131071);
        random_columns(4);
        drain();
    endtask

    task automatic test_single_channel_random();
        write_reg(REG_SINGLE_CHANNEL, 1);
        write_reg(REG_FILTER_MODE, 1);
        set_coefs(6000, -1000, 3000, 1000, -8000, 1500);
        random_columns(3);
        drain();
        write_reg(REG_FILTER_MODE, 0);
        random_columns(3);
        drain();
        write_reg(REG_SINGLE_CHANNEL, 0);
    endtask

    initial
    begin
        for (int i = 0; i < 6; i++) coef[i] = 0;
        for (int l = 0; l < LANES; l++)
        begin
            last_px[l] = 8'd0; y_prev[l] = 0; y_older[l] = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_reset_defaults();
        test_edges();
        quiet = 1;
        test_full_column();
        test_recursive_random();
        quiet = 0;
        test_simple_random();
        test_single_channel_random();
        $display("covered %0d sample words in %0d closed columns", words_sent, runs_done);
        $display("both filter modes, one and three lanes, coefficient extremes, full columns");
        if (errors == 0)
            $display("[recursive_gaussian_column] OK");
        else
            $display("[recursive_gaussian_column] ERROR");
        $finish;
    end
endmodule

// File: recursive_gaussian_column.f
hw/rtl/rgc_pkg.sv
hw/rtl/rgc_regs.sv
hw/rtl/rgc_store.sv
hw/rtl/rgc_lane.sv
hw/rtl/recursive_gaussian_column.sv
tb/tb.sv
